@@ rtl/core/rgbn_pkg.sv @@
// ----------------------------------------------------------------------------
// rgbn_pkg
// Shared types and constants for the RGB normalizer / pulse encoder.
// ----------------------------------------------------------------------------
package rgbn_pkg;

  localparam int CHAN_W      = 8;
  localparam int TICK_W      = 15;
  localparam int PULSES      = 24;
  localparam int PULSE_CNT_W = $clog2(PULSES);
  localparam int DIV_STEPS   = CHAN_W;
  localparam int DIV_CNT_W   = $clog2(DIV_STEPS);
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = TICK_W;

  localparam logic [CFG_IDX_W-1:0] REG_LINK_ENABLED    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ZERO_HIGH_TICKS = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ZERO_LOW_TICKS  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ONE_HIGH_TICKS  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ONE_LOW_TICKS   = 3'd4;

  localparam logic [TICK_W-1:0] ZERO_HIGH_RST = 15'd14;
  localparam logic [TICK_W-1:0] ZERO_LOW_RST  = 15'd32;
  localparam logic [TICK_W-1:0] ONE_HIGH_RST  = 15'd28;
  localparam logic [TICK_W-1:0] ONE_LOW_RST   = 15'd24;

  typedef enum logic [1:0] {
    FS_IDLE,
    FS_DIV,
    FS_HOLD
  } front_state_t;

  typedef struct packed {
    logic start;
    logic step;
  } lane_ctrl_t;

  typedef struct packed {
    logic [TICK_W-1:0] zero_high;
    logic [TICK_W-1:0] zero_low;
    logic [TICK_W-1:0] one_high;
    logic [TICK_W-1:0] one_low;
  } pulse_timing_t;

endpackage

@@ rtl/core/rgbn_div_lane.sv @@
// ----------------------------------------------------------------------------
// rgbn_div_lane
// One channel lane: floor(value * 255 / peak), restoring divide, one
// quotient bit per step.
// ----------------------------------------------------------------------------
module rgbn_div_lane (
  input  logic                       clk,
  input  rgbn_pkg::lane_ctrl_t       ctrl,
  input  logic [rgbn_pkg::CHAN_W-1:0] value,
  input  logic [rgbn_pkg::CHAN_W-1:0] peak,
  output logic [rgbn_pkg::CHAN_W-1:0] quot
);
  import rgbn_pkg::*;

  logic [2*CHAN_W-1:0] dividend;
  logic [CHAN_W-1:0]   rem;
  logic [CHAN_W-1:0]   qsh;     // low dividend bits shift out, quotient bits shift in
  logic [CHAN_W-1:0]   divisor;
  logic                zero;
  logic [CHAN_W:0]     trial;
  logic                qbit;

  // value*255 = (value << 8) - value
  assign dividend = {value, {CHAN_W{1'b0}}} - {{CHAN_W{1'b0}}, value};

  assign trial = {rem, qsh[CHAN_W-1]};
  assign qbit  = (trial >= {1'b0, divisor});

  always_ff @(posedge clk) begin
    if (ctrl.start) begin
      // upper half is always below peak, so quotient fits in CHAN_W bits
      rem     <= dividend[2*CHAN_W-1:CHAN_W];
      qsh     <= dividend[CHAN_W-1:0];
      divisor <= peak;
      zero    <= (peak == '0);
    end else if (ctrl.step) begin
      rem <= qbit ? CHAN_W'(trial - {1'b0, divisor}) : trial[CHAN_W-1:0];
      qsh <= {qsh[CHAN_W-2:0], qbit};
    end
  end

  assign quot = zero ? '0 : qsh;

endmodule

@@ rtl/core/rgbn_serializer.sv @@
// ----------------------------------------------------------------------------
// rgbn_serializer
// Merges the three lane results into a GRB word and sends it MSB first as
// 24 pulse transfers from an output register.
// ----------------------------------------------------------------------------
module rgbn_serializer (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          load,
  input  logic [rgbn_pkg::CHAN_W-1:0]   green_q,
  input  logic [rgbn_pkg::CHAN_W-1:0]   red_q,
  input  logic [rgbn_pkg::CHAN_W-1:0]   blue_q,
  input  rgbn_pkg::pulse_timing_t       timing,
  output logic                          load_ready,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          data_bit,
  output logic [rgbn_pkg::TICK_W-1:0]   high_ticks,
  output logic [rgbn_pkg::TICK_W-1:0]   low_ticks,
  output logic                          last_pulse
);
  import rgbn_pkg::*;

  logic [PULSES-1:0]      word;
  logic [PULSES-2:0]      shreg;
  logic [PULSE_CNT_W-1:0] remaining;
  logic                   xfer;
  logic                   next_bit;

  assign word       = {green_q, red_q, blue_q};
  assign xfer       = out_valid && out_ready;
  assign load_ready = !out_valid || (out_ready && remaining == '0);
  assign next_bit   = load ? word[PULSES-1] : shreg[PULSES-2];

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      remaining <= '0;
    end else if (load) begin
      out_valid <= 1'b1;
      remaining <= PULSE_CNT_W'(PULSES - 1);
    end else if (xfer) begin
      if (remaining != '0) begin
        remaining <= remaining - 1'b1;
      end else begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load || (xfer && remaining != '0)) begin
      data_bit   <= next_bit;
      high_ticks <= next_bit ? timing.one_high : timing.zero_high;
      low_ticks  <= next_bit ? timing.one_low : timing.zero_low;
      last_pulse <= !load && (remaining == PULSE_CNT_W'(1));
      shreg      <= load ? word[PULSES-2:0] : {shreg[PULSES-3:0], 1'b0};
    end
  end

`ifndef ASSERT_OFF
  a_load_when_free: assert property (@(posedge clk) disable iff (rst)
    load |-> load_ready)
    else $error("serializer loaded while pulses remain");

  a_last_at_end: assert property (@(posedge clk) disable iff (rst)
    (out_valid && last_pulse) |-> (remaining == '0))
    else $error("last pulse flagged with pulses remaining");

  a_drain: assert property (@(posedge clk) disable iff (rst)
    (xfer && last_pulse && !load) |=> !out_valid)
    else $error("output still valid after last pulse");
`endif

endmodule

@@ rtl/core/rgb_normalize_ws2812_encoder_unit.sv @@
// ----------------------------------------------------------------------------
// rgb_normalize_ws2812_encoder_unit
// Scales an RGB color to full brightness and encodes it as 24 GRB pulses.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_ready, red/green/blue): one color per transfer.
// Output channel (out_valid/out_ready): one pulse per transfer, carrying the
// bit value, high/low durations from the timing registers and a last flag
// on the 24th pulse. Config port: cfg_wen/cfg_index/cfg_data, written while
// the block is idle; with link_enabled at 0 colors are taken and dropped.
// The three channel lanes divide in parallel, one quotient bit per cycle,
// and out_valid rises with the first pulse after the serializer takes the
// word.
// Throughput: the single output register sends one pulse per cycle while
// out_ready is high; the next color divides while the previous one is being
// sent.
// Reset clears link_enabled to 0 and loads the default tick counts (14, 32,
// 28, 24); no output is pending after reset. A stalled receiver holds the
// current pulse; the lanes finish and wait with in_ready low until the
// serializer takes the word.
// ----------------------------------------------------------------------------
module rgb_normalize_ws2812_encoder_unit (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_wen,
  input  logic [rgbn_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [rgbn_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [rgbn_pkg::CHAN_W-1:0]       red,
  input  logic [rgbn_pkg::CHAN_W-1:0]       green,
  input  logic [rgbn_pkg::CHAN_W-1:0]       blue,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic                              data_bit,
  output logic [rgbn_pkg::TICK_W-1:0]       high_ticks,
  output logic [rgbn_pkg::TICK_W-1:0]       low_ticks,
  output logic                              last_pulse
);
  import rgbn_pkg::*;

  logic                 link_enabled;
  pulse_timing_t        timing;
  front_state_t         fstate;
  front_state_t         fstate_next;
  logic [DIV_CNT_W-1:0] div_cnt;
  logic [DIV_CNT_W-1:0] div_cnt_next;
  lane_ctrl_t           lane_ctrl;
  logic                 accept;
  logic                 ser_load;
  logic                 load_ready;
  logic [CHAN_W-1:0]    peak;
  logic [CHAN_W-1:0]    red_q;
  logic [CHAN_W-1:0]    green_q;
  logic [CHAN_W-1:0]    blue_q;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      link_enabled     <= 1'b0;
      timing.zero_high <= ZERO_HIGH_RST;
      timing.zero_low  <= ZERO_LOW_RST;
      timing.one_high  <= ONE_HIGH_RST;
      timing.one_low   <= ONE_LOW_RST;
    end else if (cfg_wen) begin
      unique case (cfg_index)
        REG_LINK_ENABLED:    link_enabled     <= cfg_data[0];
        REG_ZERO_HIGH_TICKS: timing.zero_high <= cfg_data;
        REG_ZERO_LOW_TICKS:  timing.zero_low  <= cfg_data;
        REG_ONE_HIGH_TICKS:  timing.one_high  <= cfg_data;
        REG_ONE_LOW_TICKS:   timing.one_low   <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    peak = red;
    if (green > peak) peak = green;
    if (blue > peak) peak = blue;
  end

  assign accept = in_valid && in_ready;

  // front-end sequencer: load lanes, step them, hand off to serializer
  always_comb begin
    fstate_next  = fstate;
    div_cnt_next = div_cnt;
    unique case (fstate)
      FS_IDLE: begin
        div_cnt_next = '0;
        if (accept && link_enabled) fstate_next = FS_DIV;
      end
      FS_DIV: begin
        div_cnt_next = div_cnt + 1'b1;
        if (div_cnt == DIV_CNT_W'(DIV_STEPS - 1)) fstate_next = FS_HOLD;
      end
      FS_HOLD: begin
        if (load_ready) fstate_next = FS_IDLE;
      end
      default: fstate_next = FS_IDLE;
    endcase
  end

  always_comb begin
    in_ready       = 1'b0;
    lane_ctrl      = '0;
    ser_load       = 1'b0;
    unique case (fstate)
      FS_IDLE: begin
        in_ready        = 1'b1;
        lane_ctrl.start = in_valid && link_enabled;
      end
      FS_DIV:  lane_ctrl.step = 1'b1;
      FS_HOLD: ser_load = load_ready;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fstate  <= FS_IDLE;
      div_cnt <= '0;
    end else begin
      fstate  <= fstate_next;
      div_cnt <= div_cnt_next;
    end
  end

  rgbn_div_lane u_lane_red (
    .clk(clk), .ctrl(lane_ctrl), .value(red), .peak(peak), .quot(red_q)
  );

  rgbn_div_lane u_lane_green (
    .clk(clk), .ctrl(lane_ctrl), .value(green), .peak(peak), .quot(green_q)
  );

  rgbn_div_lane u_lane_blue (
    .clk(clk), .ctrl(lane_ctrl), .value(blue), .peak(peak), .quot(blue_q)
  );

  rgbn_serializer u_serializer (
    .clk        (clk),
    .rst        (rst),
    .load       (ser_load),
    .green_q    (green_q),
    .red_q      (red_q),
    .blue_q     (blue_q),
    .timing     (timing),
    .load_ready (load_ready),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .data_bit   (data_bit),
    .high_ticks (high_ticks),
    .low_ticks  (low_ticks),
    .last_pulse (last_pulse)
  );

`ifndef ASSERT_OFF
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (accept && link_enabled) |=> !in_ready)
    else $error("input ready while lanes are dividing");

  a_drop_when_off: assert property (@(posedge clk) disable iff (rst)
    (accept && !link_enabled) |=> in_ready)
    else $error("disabled link did not drop color");

  a_hold_from_div: assert property (@(posedge clk) disable iff (rst)
    (fstate == FS_HOLD) |-> ($past(fstate) == FS_DIV || $past(fstate) == FS_HOLD))
    else $error("handoff state entered without a divide");

  a_div_len: assert property (@(posedge clk) disable iff (rst)
    $rose(fstate == FS_HOLD) |-> $past(div_cnt) == DIV_CNT_W'(DIV_STEPS - 1))
    else $error("divide finished early");
`endif

endmodule

@@ test/rgb_normalize_ws2812_encoder_unit_test.sv @@
// ----------------------------------------------------------------------------
// rgb_normalize_ws2812_encoder_unit_test
// Self-checking bench for the RGB full-brightness scaler / GRB pulse encoder.
// ----------------------------------------------------------------------------
// A directed table covers link gating, writes outside the register map, a
// link value wider than one bit, black and full-white colors, pure channels
// and timing extremes. Random colors follow over several timing settings.
// Every pulse transfer is compared field by field with pulses built from the
// table's known words or a local scaler, and a local copy of the registers.
// ----------------------------------------------------------------------------
module rgb_normalize_ws2812_encoder_unit_test;
  import rgbn_pkg::*;

  localparam int SETTLE_CYCLES = 40;
  localparam int DIR_ROWS      = 28;
  localparam int PHASES        = 8;
  localparam int DARK_PHASE    = 3;

  // indexes past the register map; writes there must not land anywhere
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_LO  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_MID = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_HI  = 3'd7;

  typedef enum logic {ROW_CFG, ROW_COLOR} row_kind_t;
  typedef enum logic [1:0] {RX_STREAM, RX_COIN, RX_SPARSE, RX_PERIODIC} rx_mode_t;

  typedef struct packed {
    row_kind_t             kind;
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0] data;
    logic [CHAN_W-1:0]     r;
    logic [CHAN_W-1:0]     g;
    logic [CHAN_W-1:0]     b;
    logic                  known;
    logic [PULSES-1:0]     word;
  } stim_row_t;

  typedef struct packed {
    logic              bit_val;
    logic [TICK_W-1:0] hi;
    logic [TICK_W-1:0] lo;
    logic              last;
  } pulse_t;

  // known = 1: the GRB word is read straight off the color
  localparam stim_row_t DIR_TABLE [DIR_ROWS] = '{
    '{ROW_COLOR, '0, '0, 8'd10, 8'd20, 8'd30, 1'b0, 24'h0},
    '{ROW_COLOR, '0, '0, 8'd0, 8'd0, 8'd0, 1'b0, 24'h0},
    '{ROW_CFG, REG_UNUSED_LO, 15'h0001, 8'd0, 8'd0, 8'd0, 1'b0, 24'h0},
    '{ROW_CFG, REG_UNUSED_HI, 15'h7FFF, 8'd0, 8'd0, 8'd0, 1'b0, 24'h0},
    '{ROW_COLOR, '0, '0, 8'd255, 8'd255, 8'd255, 1'b0, 24'h0},
    '{ROW_CFG, REG_LINK_ENABLED, 15'h7FFE, 8'd0, 8'd0, 8'd0, 1'b0, 24'h0},
    '{ROW_COLOR, '0, '0, 8'd1, 8'd2, 8'd3, 1'b0, 24'h0},
    '{ROW_CFG, REG_LINK_ENABLED, 15'h7FFF, 8'd0, 8'd0, 8'd0, 1'b0, 24'h0},
    '{ROW_COLOR, '0, '0, 8'd0, 8'd0, 8'd0, 1'b1, 24'h000000},
    '{ROW_COLOR, '0, '0, 8'd255, 8'd255, 8'd255, 1'b1, 24'hFFFFFF},
    '{ROW_COLOR, '0, '0, 8'd255, 8'd0, 8'd0, 1'b1, 24'h00FF00},
    '{ROW_COLOR, '0, '0, 8'd0, 8'd255, 8'd0, 1'b1, 24'hFF0000},
    '{ROW_COLOR, '0, '0, 8'd0, 8'd0, 8'd255, 1'b1, 24'h0000FF},
    '{ROW_COLOR, '0, '0, 8'd1, 8'd1, 8'd1, 1'b1, 24'hFFFFFF},
    '{ROW_COLOR, '0, '0, 8'd0, 8'd1, 8'd0, 1'b1, 24'hFF0000},
    '{ROW_COLOR, '0, '0, 8'd128, 8'd64, 8'd1, 1'b0, 24'h0},
    '{ROW_COLOR, '0, '0, 8'd254, 8'd255, 8'd1, 1'b0, 24'h0},
    '{ROW_COLOR, '0, '0, 8'd3, 8'd2, 8'd1, 1'b0, 24'h0},
    '{ROW_CFG, REG_ZERO_HIGH_TICKS, 15'h0000, 8'd0, 8'd0, 8'd0, 1'b0, 24'h0},
    '{ROW_CFG, REG_ZERO_LOW_TICKS, 15'h7FFF, 8'd0, 8'd0, 8'd0, 1'b0, 24'h0},
    '{ROW_CFG, REG_ONE_HIGH_TICKS, 15'h7FFF, 8'd0, 8'd0, 8'd0, 1'b0, 24'h0},
    '{ROW_CFG, REG_ONE_LOW_TICKS, 15'h0000, 8'd0, 8'd0, 8'd0, 1'b0, 24'h0},
    '{ROW_COLOR, '0, '0, 8'hAA, 8'h55, 8'hFF, 1'b0, 24'h0},
    '{ROW_COLOR, '0, '0, 8'd255, 8'd255, 8'd255, 1'b1, 24'hFFFFFF},
    '{ROW_COLOR, '0, '0, 8'd0, 8'd0, 8'd0, 1'b1, 24'h000000},
    '{ROW_CFG, REG_UNUSED_MID, 15'h2AAA, 8'd0, 8'd0, 8'd0, 1'b0, 24'h0},
    '{ROW_COLOR, '0, '0, 8'd200, 8'd100, 8'd50, 1'b0, 24'h0},
    '{ROW_COLOR, '0, '0, 8'h7F, 8'h80, 8'h01, 1'b0, 24'h0}
  };

  logic                  clk        = 1'b0;
  logic                  rst        = 1'b1;
  logic                  cfg_wen    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index  = '0;
  logic [CFG_DATA_W-1:0] cfg_data   = '0;
  logic                  in_valid   = 1'b0;
  logic                  in_ready;
  logic [CHAN_W-1:0]     red        = '0;
  logic [CHAN_W-1:0]     green      = '0;
  logic [CHAN_W-1:0]     blue       = '0;
  logic                  out_valid;
  logic                  out_ready  = 1'b0;
  logic                  data_bit;
  logic [TICK_W-1:0]     high_ticks;
  logic [TICK_W-1:0]     low_ticks;
  logic                  last_pulse;

  // local copy of the registers
  logic          link_on = 1'b0;
  pulse_timing_t timing  = '{ZERO_HIGH_RST, ZERO_LOW_RST, ONE_HIGH_RST, ONE_LOW_RST};

  pulse_t   pending_pulses[$];
  int       mismatches = 0;
  int       burst_left = 0;
  bit       steady     = 1'b0;
  rx_mode_t rx_mode    = RX_STREAM;
  int       rx_left    = 0;

  rgb_normalize_ws2812_encoder_unit i_dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_wen    (cfg_wen),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .red        (red),
    .green      (green),
    .blue       (blue),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .data_bit   (data_bit),
    .high_ticks (high_ticks),
    .low_ticks  (low_ticks),
    .last_pulse (last_pulse)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #5_000_000;
    $display("simulation failed");
    $finish;
  end

  function automatic logic [CHAN_W-1:0] scale_to_full(input logic [CHAN_W-1:0] v,
                                                       input logic [CHAN_W-1:0] peak);
    int unsigned q;
    if (v == 0 || peak == 0) return '0;
    q = (v * 32'd255) / peak;
    return q[CHAN_W-1:0];
  endfunction

  function automatic logic [PULSES-1:0] normalized_grb(input logic [CHAN_W-1:0] r, g, b);
    logic [CHAN_W-1:0] peak;
    peak = r;
    if (g > peak) peak = g;
    if (b > peak) peak = b;
    return {scale_to_full(g, peak), scale_to_full(r, peak), scale_to_full(b, peak)};
  endfunction

  // MSB goes out first; the 24th pulse carries the last flag
  function automatic void queue_pulses(input logic [PULSES-1:0] word);
    pulse_t p;
    for (int k = 0; k < PULSES; k++) begin
      p.bit_val = word[PULSES-1-k];
      p.hi      = p.bit_val ? timing.one_high : timing.zero_high;
      p.lo      = p.bit_val ? timing.one_low : timing.zero_low;
      p.last    = (k == PULSES - 1);
      pending_pulses.push_back(p);
    end
  endfunction

  function automatic logic [TICK_W-1:0] random_ticks();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return '1;
      default: return TICK_W'($urandom);
    endcase
  endfunction

  task automatic flag_mismatch(input string what, input int got, input int want);
    $display("ERROR at %0t: %s: got %0d, expected %0d", $time, what, got, want);
    mismatches++;
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_wen   <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    cfg_wen <= 1'b0;
    case (idx)
      REG_LINK_ENABLED:    link_on = data[0];
      REG_ZERO_HIGH_TICKS: timing.zero_high = data;
      REG_ZERO_LOW_TICKS:  timing.zero_low = data;
      REG_ONE_HIGH_TICKS:  timing.one_high = data;
      REG_ONE_LOW_TICKS:   timing.one_low = data;
      default: ;
    endcase
    @(posedge clk);
  endtask

  // dropped colors leave nothing pending, so give the pipe time to empty
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_pulses.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic pace();
    if (burst_left == 0) begin
      if (!steady) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end
      burst_left = $urandom_range(1, 20);
    end
    burst_left--;
  endtask

  task automatic push_color(input logic [CHAN_W-1:0] r, g, b,
                            input logic known, input logic [PULSES-1:0] word);
    pace();
    in_valid <= 1'b1;
    red      <= r;
    green    <= g;
    blue     <= b;
    do @(posedge clk); while (!in_ready);
    if (link_on) queue_pulses(known ? word : normalized_grb(r, g, b));
  endtask

  task automatic random_color(output logic [CHAN_W-1:0] r, g, b);
    logic [CHAN_W-1:0] v;
    int                pick;
    r    = CHAN_W'($urandom);
    g    = CHAN_W'($urandom);
    b    = CHAN_W'($urandom);
    v    = CHAN_W'($urandom);
    pick = $urandom_range(0, 2);
    case ($urandom_range(0, 5))
      1: begin
        r = CHAN_W'($urandom_range(0, 3));
        g = CHAN_W'($urandom_range(0, 3));
        b = CHAN_W'($urandom_range(0, 3));
      end
      2: begin
        if (pick == 0) r = '1;
        else if (pick == 1) g = '1;
        else b = '1;
      end
      3: begin
        r = v;
        g = v;
        b = v;
      end
      4: begin
        if (pick == 0) r = '0;
        else if (pick == 1) g = '0;
        else b = '0;
      end
      5: begin
        if (pick != 0) r = '0;
        if (pick != 1) g = '0;
        if (pick != 2) b = '0;
      end
      default: ;
    endcase
  endtask

  always @(posedge clk) begin
    if (rx_left == 0) begin
      rx_mode <= rx_mode_t'($urandom_range(0, 3));
      rx_left <= 128;
    end else begin
      rx_left <= rx_left - 1;
    end
    case (rx_mode)
      RX_STREAM: out_ready <= 1'b1;
      RX_COIN:   out_ready <= 1'($urandom_range(0, 1));
      RX_SPARSE: out_ready <= ($urandom_range(0, 3) == 0);
      default:   out_ready <= (rx_left[2:0] != 3'd0);
    endcase
  end

  always @(posedge clk) begin
    pulse_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_pulses.size() == 0) begin
        flag_mismatch("pulse transfer with nothing pending", 1, 0);
      end else begin
        want = pending_pulses.pop_front();
        if (data_bit !== want.bit_val) flag_mismatch("data_bit", data_bit, want.bit_val);
        if (high_ticks !== want.hi) flag_mismatch("high_ticks", high_ticks, want.hi);
        if (low_ticks !== want.lo) flag_mismatch("low_ticks", low_ticks, want.lo);
        if (last_pulse !== want.last) flag_mismatch("last_pulse", last_pulse, want.last);
      end
    end
  end

  initial begin
    logic [CHAN_W-1:0]     r, g, b;
    logic [CFG_DATA_W-1:0] link_data;
    stim_row_t             row;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    for (int i = 0; i < DIR_ROWS; i++) begin
      row = DIR_TABLE[i];
      if (row.kind == ROW_CFG) begin
        wait_idle();
        write_reg(row.idx, row.data);
      end else begin
        push_color(row.r, row.g, row.b, row.known, row.word);
      end
    end

    for (int p = 0; p < PHASES; p++) begin
      wait_idle();
      steady       = (p % 3 == 2);
      link_data    = CFG_DATA_W'($urandom);
      link_data[0] = (p != DARK_PHASE);
      write_reg(REG_LINK_ENABLED, link_data);
      write_reg(REG_ZERO_HIGH_TICKS, (p == 1) ? '1 : (p == 2) ? '0 : random_ticks());
      write_reg(REG_ZERO_LOW_TICKS, (p == 1) ? '1 : (p == 2) ? '0 : random_ticks());
      write_reg(REG_ONE_HIGH_TICKS, (p == 1) ? '1 : (p == 2) ? '0 : random_ticks());
      write_reg(REG_ONE_LOW_TICKS, (p == 1) ? '1 : (p == 2) ? '0 : random_ticks());
      if ($urandom_range(0, 1) == 1)
        write_reg(CFG_IDX_W'($urandom_range(REG_UNUSED_LO, REG_UNUSED_HI)),
                  CFG_DATA_W'($urandom));
      repeat ((p == DARK_PHASE) ? 12 : 50) begin
        random_color(r, g, b);
        push_color(r, g, b, 1'b0, '0);
      end
    end

    wait_idle();
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

@@ files.f @@
rtl/core/rgbn_pkg.sv
rtl/core/rgbn_div_lane.sv
rtl/core/rgbn_serializer.sv
rtl/core/rgb_normalize_ws2812_encoder_unit.sv
test/rgb_normalize_ws2812_encoder_unit_test.sv
